### hw/rtl/point_direction_degrees_top_macros.svh
// Assertion macros shared by the point direction RTL.
`ifndef POINT_DIRECTION_DEGREES_TOP_MACROS_SVH
`define POINT_DIRECTION_DEGREES_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PDD_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PDD_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pdd_pkg.sv
// Shared types, constants and the arctangent table for the point direction pipeline.
package pdd_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int ANGLE_FRAC_DEF  = 8;

	localparam int CORDIC_STAGES = 28;
	localparam int CORDIC_XW     = 64;  // x/y datapath, values stay below 2^62
	localparam int CORDIC_ZW     = 33;  // signed angle accumulator, Q24 degrees
	localparam int CORDIC_PRE    = 60;  // operands are aligned to this many bits
	localparam int DEG_Q         = 24;
	localparam int ANG_W         = 33;  // unsigned Q24 angle, below 360 degrees

	localparam logic [63:0] RAD_TO_DEG_Q26 = 64'd3845054675;

	localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90)  << DEG_Q;
	localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(180) << DEG_Q;
	localparam logic [ANG_W-1:0] ANG_270 = ANG_W'(270) << DEG_Q;
	localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(360) << DEG_Q;

	// How the final angle is formed from the CORDIC result t.
	typedef enum logic [2:0] {
		PL_ZERO,
		PL_90,
		PL_180,
		PL_270,
		PL_T,
		PL_180_MINUS_T,
		PL_180_PLUS_T,
		PL_360_MINUS_T
	} place_e;

	typedef struct packed {
		logic   valid;
		place_e place;
	} tag_t;

	typedef logic signed [CORDIC_ZW-1:0] atan_tbl_t [CORDIC_STAGES];

	// Shift-subtract quotient, only used while building the table.
	function automatic longint unsigned div_shift_sub(longint unsigned num,
			longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in Q24 degrees; series in Q60, rounded to Q30, scaled by 180/pi.
	function automatic atan_tbl_t atan_tbl_build();
		atan_tbl_t           tbl;
		longint              sum;
		longint              term;
		longint unsigned     r30;
		longint unsigned     d56;
		int                  sh;
		int                  i;
		int                  k;
		for (i = 0; i < CORDIC_STAGES; i++) begin
			if (i == 0) begin
				tbl[i] = CORDIC_ZW'(longint'(45) << DEG_Q);
			end else begin
				sum = 0;
				for (k = 0; k < 30; k++) begin
					sh = i * (2 * k + 1);
					if (sh < 60) begin
						term = longint'(div_shift_sub(64'd1 << (60 - sh), 64'(2 * k + 1)));
						if ((k & 1) != 0) begin
							sum = sum - term;
						end else begin
							sum = sum + term;
						end
					end
				end
				r30    = (longint'(sum) + (longint'(1) << 29)) >> 30;
				d56    = r30 * RAD_TO_DEG_Q26;
				tbl[i] = CORDIC_ZW'((d56 + (64'd1 << 31)) >> 32);
			end
		end
		return tbl;
	endfunction

	localparam atan_tbl_t ATAN_TBL = atan_tbl_build();

endpackage

### hw/rtl/pdd_prep.sv
// Front stage: coordinate differences, magnitudes and angle placement code.
module pdd_prep import pdd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic signed [COORD_WIDTH-1:0]  from_x,
	input  logic signed [COORD_WIDTH-1:0]  from_y,
	input  logic signed [COORD_WIDTH-1:0]  to_x,
	input  logic signed [COORD_WIDTH-1:0]  to_y,
	output logic signed [CORDIC_XW-1:0]    x_out,
	output logic signed [CORDIC_XW-1:0]    y_out,
	output tag_t                           tag_out
);

	localparam int GS = CORDIC_PRE - COORD_WIDTH;

	logic signed [COORD_WIDTH:0]   dx;
	logic signed [COORD_WIDTH:0]   dy;
	logic        [COORD_WIDTH:0]   dx_mag;
	logic        [COORD_WIDTH:0]   dy_mag;
	logic signed [CORDIC_XW-1:0]   x0;
	logic signed [CORDIC_XW-1:0]   y0;
	place_e                        place;

	logic                          vld_s1;
	logic signed [CORDIC_XW-1:0]   x_s1;
	logic signed [CORDIC_XW-1:0]   y_s1;
	place_e                        place_s1;

	always_comb begin
		dx     = {from_x[COORD_WIDTH-1], from_x} - {to_x[COORD_WIDTH-1], to_x};
		dy     = {from_y[COORD_WIDTH-1], from_y} - {to_y[COORD_WIDTH-1], to_y};
		dx_mag = dx[COORD_WIDTH] ? (~dx + 1'b1) : dx;
		dy_mag = dy[COORD_WIDTH] ? (~dy + 1'b1) : dy;
		x0     = CORDIC_XW'({dx_mag[COORD_WIDTH-1:0], {GS{1'b0}}});
		y0     = CORDIC_XW'({dy_mag[COORD_WIDTH-1:0], {GS{1'b0}}});

		if (dx == '0 && dy == '0) begin
			place = PL_ZERO;
		end else if (dx == '0) begin
			place = dy[COORD_WIDTH] ? PL_270 : PL_90;
		end else if (dy == '0) begin
			place = dx[COORD_WIDTH] ? PL_ZERO : PL_180;
		end else if (dx[COORD_WIDTH] && !dy[COORD_WIDTH]) begin
			place = PL_T;
		end else if (!dx[COORD_WIDTH] && !dy[COORD_WIDTH]) begin
			place = PL_180_MINUS_T;
		end else if (!dx[COORD_WIDTH]) begin
			place = PL_180_PLUS_T;
		end else begin
			place = PL_360_MINUS_T;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= x0;
			y_s1     <= y0;
			place_s1 <= place;
		end
	end

	assign x_out   = x_s1;
	assign y_out   = y_s1;
	assign tag_out = '{valid: vld_s1, place: place_s1};

endmodule

### hw/rtl/pdd_cordic.sv
// Pipelined CORDIC vectoring unit, one micro-rotation per register stage.
`include "point_direction_degrees_top_macros.svh"

module pdd_cordic import pdd_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic signed [CORDIC_XW-1:0]  x_in,
	input  logic signed [CORDIC_XW-1:0]  y_in,
	input  tag_t                         tag_in,
	output logic signed [CORDIC_ZW-1:0]  z_out,
	output tag_t                         tag_out
);

	localparam int N = CORDIC_STAGES;

	// x/y are not needed after the last rotation, so only N-1 of them are kept
	logic signed [CORDIC_XW-1:0] x_s [N-1];
	logic signed [CORDIC_XW-1:0] y_s [N-1];
	logic signed [CORDIC_ZW-1:0] z_s [N];
	logic        [N-1:0]         vld_s;
	place_e                      place_s [N];

	logic signed [CORDIC_XW-1:0] x_nx [N-1];
	logic signed [CORDIC_XW-1:0] y_nx [N-1];
	logic signed [CORDIC_ZW-1:0] z_nx [N];
	logic signed [CORDIC_XW-1:0] xp_a [N];
	logic signed [CORDIC_XW-1:0] yp_a [N];
	logic signed [CORDIC_ZW-1:0] zp_a [N];

	always_comb begin
		logic signed [CORDIC_XW-1:0] xs;
		logic signed [CORDIC_XW-1:0] ys;
		logic signed [CORDIC_XW-1:0] xn;
		logic signed [CORDIC_XW-1:0] yn;
		xp_a[0] = x_in;
		yp_a[0] = y_in;
		zp_a[0] = '0;
		for (int i = 1; i < N; i++) begin
			xp_a[i] = x_s[i-1];
			yp_a[i] = y_s[i-1];
			zp_a[i] = z_s[i-1];
		end
		for (int i = 0; i < N; i++) begin
			xs = xp_a[i] >>> i;
			ys = yp_a[i] >>> i;
			if (!yp_a[i][CORDIC_XW-1]) begin
				xn      = xp_a[i] + ys;
				yn      = yp_a[i] - xs;
				z_nx[i] = zp_a[i] + ATAN_TBL[i];
			end else begin
				xn      = xp_a[i] - ys;
				yn      = yp_a[i] + xs;
				z_nx[i] = zp_a[i] - ATAN_TBL[i];
			end
			if (i < N - 1) begin
				x_nx[i] = xn;
				y_nx[i] = yn;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], tag_in.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				z_s[i] <= z_nx[i];
			end
			for (int i = 0; i < N - 1; i++) begin
				x_s[i] <= x_nx[i];
				y_s[i] <= y_nx[i];
			end
			place_s[0] <= tag_in.place;
			for (int i = 1; i < N; i++) begin
				place_s[i] <= place_s[i-1];
			end
		end
	end

	assign z_out   = z_s[N-1];
	assign tag_out = '{valid: vld_s[N-1], place: place_s[N-1]};

	`PDD_ASSERT_NEXT(a_stall_keeps_valids, !en, $stable(vld_s), "cordic valids moved during stall")
	`PDD_ASSERT_NEXT(a_valid_advances, en && tag_in.valid, vld_s[0], "cordic dropped an entering item")

endmodule

### hw/rtl/pdd_post.sv
// Back end: clamp, quadrant placement, rounding and the output register.
`include "point_direction_degrees_top_macros.svh"

module pdd_post import pdd_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic signed [CORDIC_ZW-1:0]     z_in,
	input  tag_t                            tag_in,
	output logic                            en,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [8+ANGLE_FRAC_BITS:0]      angle_deg
);

	localparam int OUT_W = 9 + ANGLE_FRAC_BITS;
	localparam int RSH   = DEG_Q - ANGLE_FRAC_BITS;
	localparam logic [ANG_W:0]     ROUND_ADD = (ANG_W + 1)'(1) << (RSH - 1);
	localparam logic [OUT_W-1:0]   FULL      = OUT_W'(360 << ANGLE_FRAC_BITS);
	localparam logic [OUT_W-1:0]   OUT_90    = OUT_W'(90 << ANGLE_FRAC_BITS);

	logic [ANG_W-1:0]    t_clamp;
	logic [ANG_W-1:0]    ang;
	logic [ANG_W:0]      ang_rnd;
	logic [OUT_W-1:0]    res;

	logic                vld_s30;
	place_e              place_s30;
	logic [ANG_W-1:0]    ang_s30;
	logic                vld_s31;
	logic [OUT_W-1:0]    angle_s31;

	assign en = !vld_s31 || out_ready;

	always_comb begin
		if (z_in[CORDIC_ZW-1]) begin
			t_clamp = '0;
		end else if (z_in > $signed({1'b0, ANG_90[CORDIC_ZW-2:0]})) begin
			t_clamp = ANG_90;
		end else begin
			t_clamp = ANG_W'(z_in);
		end

		unique case (tag_in.place)
			PL_ZERO:        ang = '0;
			PL_90:          ang = ANG_90;
			PL_180:         ang = ANG_180;
			PL_270:         ang = ANG_270;
			PL_T:           ang = t_clamp;
			PL_180_MINUS_T: ang = ANG_180 - t_clamp;
			PL_180_PLUS_T:  ang = ANG_180 + t_clamp;
			PL_360_MINUS_T: ang = ANG_360 - t_clamp;
			default:        ang = '0;
		endcase
	end

	always_comb begin
		ang_rnd = {1'b0, ang_s30} + ROUND_ADD;
		res     = OUT_W'(ang_rnd >> RSH);
		if (res >= FULL) begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s30 <= 1'b0;
			vld_s31 <= 1'b0;
		end else if (en) begin
			vld_s30 <= tag_in.valid;
			vld_s31 <= vld_s30;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			place_s30 <= tag_in.place;
			ang_s30   <= ang;
			angle_s31 <= res;
		end
	end

	assign out_valid = vld_s31;
	assign angle_deg = angle_s31;

	`PDD_ASSERT_NOW(a_out_range, vld_s31, angle_s31 < FULL, "angle not below full circle")
	`PDD_ASSERT_NEXT(a_axis_90, en && vld_s30 && place_s30 == PL_90, angle_s31 == OUT_90, "axis angle not 90")
	`PDD_ASSERT_NEXT(a_axis_0, en && vld_s30 && place_s30 == PL_ZERO, angle_s31 == '0, "zero angle not 0")

endmodule

### hw/rtl/point_direction_degrees_top.sv
// An input transaction passes the prep register, the CORDIC pipe and the back-end registers to its result.
// Throughput: one transaction per cycle while the output is not stalled; the whole pipe advances together.
// The CORDIC pipe has 28 stages, one micro-rotation per register stage.
// A stall at the output freezes every stage; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
module point_direction_degrees_top import pdd_pkg::*; #(
	parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [COORD_WIDTH-1:0]  from_x,
	input  logic signed [COORD_WIDTH-1:0]  from_y,
	input  logic signed [COORD_WIDTH-1:0]  to_x,
	input  logic signed [COORD_WIDTH-1:0]  to_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [8+ANGLE_FRAC_BITS:0]     angle_deg
);

	// Global advance: high when the output register is empty or being drained.
	logic                         en;

	// Prep -> CORDIC: aligned magnitudes plus the placement tag.
	logic signed [CORDIC_XW-1:0]  prep_x;
	logic signed [CORDIC_XW-1:0]  prep_y;
	tag_t                         prep_tag;

	// CORDIC -> back end: first-quadrant angle (Q24 degrees) and tag.
	logic signed [CORDIC_ZW-1:0]  cordic_z;
	tag_t                         cordic_tag;

	// Input side accepts whenever the pipe moves; a result held in the output
	// register stalls the whole pipe, so no new transaction enters while it waits.
	assign in_ready = en;

	// Stage 1: dx/dy, absolute values aligned for the CORDIC, axis and quadrant
	// handling decided here and carried alongside the data.
	pdd_prep #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.from_x  (from_x),
		.from_y  (from_y),
		.to_x    (to_x),
		.to_y    (to_y),
		.x_out   (prep_x),
		.y_out   (prep_y),
		.tag_out (prep_tag)
	);

	// Stages 2-29: vectoring CORDIC, atan(|dy|/|dx|) accumulated in Q24 degrees.
	pdd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.x_in   (prep_x),
		.y_in   (prep_y),
		.tag_in (prep_tag),
		.z_out  (cordic_z),
		.tag_out(cordic_tag)
	);

	// Stages 30-31: clamp to [0, 90], place into [0, 360), round half up to the
	// output fraction, wrap a full circle to zero; stage 31 is the output register.
	pdd_post #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.z_in     (cordic_z),
		.tag_in   (cordic_tag),
		.en       (en),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.angle_deg(angle_deg)
	);

endmodule
